### rtl/rbj_pkg.sv
package rbj_pkg;

    // Field widths of the words on the two channels.
    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int HEAD_BITS  = FRAC_BITS + 3;
    localparam int RJAC_BITS  = FRAC_BITS + 2;
    localparam int RANGE_BITS = WORD_BITS - 1;
    localparam int IN_BITS    = 152;
    localparam int OUT_BITS   = 256;

    // Iteration counts of the shared-stage pipeline.
    localparam int DIV_STEPS    = 32;
    localparam int RSQRT_BITS   = 33;
    localparam int JSQRT_BITS   = 17;
    localparam int CORDIC_STEPS = 31;
    localparam int ITER_STAGES  = DIV_STEPS + JSQRT_BITS;

    // Angles in radians, signed Q5.30 (35 bits, 30 fraction bits).
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;

    // Everything one item carries through the iteration stages.
    typedef struct packed {
        logic signed [18:0] hs;
        logic               nx;
        logic               ny;
        logic               zero;
        logic               axz;
        logic               ayz;
        logic [64:0]        d2;
        logic [64:0]        rg_rem;
        logic [32:0]        rg_root;
        logic [64:0]        qx_rem;
        logic [31:0]        qx_q;
        logic               qx_ov;
        logic [64:0]        qy_rem;
        logic [31:0]        qy_q;
        logic               qy_ov;
        logic [64:0]        rx_rem;
        logic [32:0]        rx_q;
        logic [32:0]        rx_srem;
        logic [16:0]        rx_root;
        logic [64:0]        ry_rem;
        logic [32:0]        ry_q;
        logic [32:0]        ry_srem;
        logic [16:0]        ry_root;
        logic signed [43:0] cx;
        logic signed [43:0] cy;
        logic signed [32:0] cz;
    } t_work;

endpackage

### rtl/rbj_iter.sv
module rbj_iter import rbj_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_work i_work,
    output logic  o_valid,
    output t_work o_work
);

    // Arctangent of 2^-i in Q30; small angles equal the shift itself.
    function automatic logic signed [32:0] atan_q30(input int i);
        logic signed [32:0] one;
        logic signed [32:0] t;
        one = 33'sd1;
        case (i)
            0: begin t = 33'sd843314856; end
            1: begin t = 33'sd497837829; end
            2: begin t = 33'sd263043836; end
            3: begin t = 33'sd133525158; end
            4: begin t = 33'sd67021686; end
            5: begin t = 33'sd33543515; end
            6: begin t = 33'sd16775850; end
            7: begin t = 33'sd8388437; end
            8: begin t = 33'sd4194282; end
            9: begin t = 33'sd2097149; end
            default: begin t = one <<< (30 - i); end
        endcase
        return t;
    endfunction

    // One restoring division step: shift in a zero, subtract when it fits.
    function automatic logic [65:0] div_step(input logic [64:0] rem, input logic [64:0] d);
        logic [65:0] r2;
        logic [65:0] res;
        r2 = {rem, 1'b0};
        if (r2 >= {1'b0, d}) begin
            res = {1'b1, 65'(r2 - {1'b0, d})};
        end else begin
            res = {1'b0, r2[64:0]};
        end
        return res;
    endfunction

    // One root bit of the wide square root; remainder is n - root^2.
    function automatic logic [97:0] sqrt_wide(input logic [64:0] rem, input logic [32:0] root,
                                              input int b);
        logic [66:0] t;
        logic [64:0] r;
        logic [32:0] q;
        r = rem;
        q = root;
        t = ({34'd0, root} << (b + 1)) + (67'd1 << (2 * b));
        if ({2'b00, rem} >= t) begin
            r = rem - t[64:0];
            q = root | (33'd1 << b);
        end
        return {q, r};
    endfunction

    // One root bit of the narrow square root used for the range Jacobian.
    function automatic logic [49:0] sqrt_narrow(input logic [32:0] rem, input logic [16:0] root,
                                                input int b);
        logic [34:0] t;
        logic [32:0] r;
        logic [16:0] q;
        r = rem;
        q = root;
        t = ({18'd0, root} << (b + 1)) + (35'd1 << (2 * b));
        if ({2'b00, rem} >= t) begin
            r = rem - t[32:0];
            q = root | (17'd1 << b);
        end
        return {q, r};
    endfunction

    // Work of stage k: one bit of each unit still running at that depth.
    function automatic t_work rbj_step(input int k, input t_work w);
        t_work              o;
        logic [97:0]        sw;
        logic [65:0]        dq;
        logic [49:0]        sn;
        logic [32:0]        nrem;
        logic signed [43:0] x0;
        logic signed [43:0] y0;
        logic signed [43:0] xs;
        logic signed [43:0] ys;
        logic signed [32:0] t;
        o = w;
        if (k < RSQRT_BITS) begin
            sw = sqrt_wide(w.rg_rem, w.rg_root, RSQRT_BITS - 1 - k);
            o.rg_root = sw[97:65];
            o.rg_rem  = sw[64:0];
        end
        if (k < DIV_STEPS) begin
            dq = div_step(w.qx_rem, w.d2);
            o.qx_rem = dq[64:0];
            o.qx_q   = {w.qx_q[30:0], dq[65]};
            dq = div_step(w.qy_rem, w.d2);
            o.qy_rem = dq[64:0];
            o.qy_q   = {w.qy_q[30:0], dq[65]};
            dq = div_step(w.rx_rem, w.d2);
            o.rx_rem = dq[64:0];
            o.rx_q   = {w.rx_q[31:0], dq[65]};
            dq = div_step(w.ry_rem, w.d2);
            o.ry_rem = dq[64:0];
            o.ry_q   = {w.ry_q[31:0], dq[65]};
        end else begin
            nrem = (k == DIV_STEPS) ? w.rx_q : w.rx_srem;
            sn = sqrt_narrow(nrem, w.rx_root, ITER_STAGES - 1 - k);
            o.rx_root = sn[49:33];
            o.rx_srem = sn[32:0];
            nrem = (k == DIV_STEPS) ? w.ry_q : w.ry_srem;
            sn = sqrt_narrow(nrem, w.ry_root, ITER_STAGES - 1 - k);
            o.ry_root = sn[49:33];
            o.ry_srem = sn[32:0];
        end
        if (k < CORDIC_STEPS) begin
            x0 = w.cx;
            y0 = w.cy;
            xs = x0 >>> k;
            ys = y0 >>> k;
            t  = atan_q30(k);
            // Rotation stops for good once the residual is exactly zero.
            if (y0 > 44'sd0) begin
                o.cx = x0 + ys;
                o.cy = y0 - xs;
                o.cz = w.cz + t;
            end else if (y0 < 44'sd0) begin
                o.cx = x0 - ys;
                o.cy = y0 + xs;
                o.cz = w.cz - t;
            end
        end
        return o;
    endfunction

    logic [ITER_STAGES-1:0] r_v;
    t_work                  r_w [ITER_STAGES];
    t_work                  n_w [ITER_STAGES];

    // Stage logic, each stage fed by the register before it.
    for (genvar k = 0; k < ITER_STAGES; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign n_w[k] = rbj_step(k, i_work);
        end else begin : g_next
            assign n_w[k] = rbj_step(k, r_w[k-1]);
        end
    end

    // Valid bits move with the data whenever the pipeline advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[ITER_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w <= n_w;
        end
    end

    assign o_valid = r_v[ITER_STAGES-1];
    assign o_work  = r_w[ITER_STAGES-1];

endmodule

### rtl/range_bearing_measurement_jacobian_unit.sv
// Range/bearing observation model with Jacobians, Q16.16 fixed point.
// Input channel (s_axis): one word per vehicle pose and landmark pair.
// Output channel (m_axis): one word per input word, in the same order,
// holding range, bearing, the landmark Jacobian and the vehicle position
// Jacobian; tuser flags a landmark that sits on the vehicle.
// Pipeline: a taken input word passes through four front stages
// (difference, squares, sum and CORDIC normalization, unit setup),
// 49 iteration stages (bit-serial dividers, square roots and CORDIC
// rotations, one bit or one rotation per stage) and four finish
// stages, the last of which is the output register.
// Throughput: one word per cycle unless stalled; all stages advance together.
// Stall: while a result waits in the output register and the receiver holds
// tready low, the whole pipeline holds and s_axis tready is low; nothing is
// lost or repeated. An empty output register lets the pipeline advance.
// Reset: synchronous, active low; clears all valid bits, so the block is
// empty and ready on the first cycle after reset.
module range_bearing_measurement_jacobian_unit import rbj_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // vehicle_x, vehicle_y, vehicle_heading, landmark_x, landmark_y, zero pad
    input  logic [IN_BITS-1:0]  i_s_axis_tdata,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // range, bearing, drange_dlm_x, dbearing_dlm_x, drange_dlm_y,
    // dbearing_dlm_y, drange_dveh_x, dbearing_dveh_x, drange_dveh_y,
    // dbearing_dveh_y, zero pad
    output logic [OUT_BITS-1:0] o_m_axis_tdata,
    // zero_distance
    output logic                o_m_axis_tuser
);

    // Saturated bearing Jacobian term with its sign applied.
    function automatic logic [31:0] sat_db(input logic [31:0] q, input logic ov,
                                           input logic neg);
        logic [31:0] lim;
        logic [31:0] m;
        lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        m = (ov || (q > lim)) ? lim : q;
        return neg ? (32'd0 - m) : m;
    endfunction

    // Range Jacobian term with its sign applied.
    function automatic logic [RJAC_BITS-1:0] enc_dr(input logic [16:0] root, input logic neg);
        logic [RJAC_BITS-1:0] m;
        m = {1'b0, root};
        return neg ? (18'd0 - m) : m;
    endfunction

    logic en;
    logic r_o_v;

    // The pipeline advances unless a result sits unclaimed at the output.
    assign en              = !r_o_v || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // ---------------------------------------------------------------
    // Stage 1: differences and their magnitudes.
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [31:0]        n_s1_ax;
    logic [31:0]        n_s1_ay;
    logic               r_s1_v;
    logic [31:0]        r_s1_ax;
    logic [31:0]        r_s1_ay;
    logic               r_s1_nx;
    logic               r_s1_ny;
    logic signed [18:0] r_s1_hs;

    assign dx = $signed({i_s_axis_tdata[114], i_s_axis_tdata[114:83]})
              - $signed({i_s_axis_tdata[31], i_s_axis_tdata[31:0]});
    assign dy = $signed({i_s_axis_tdata[146], i_s_axis_tdata[146:115]})
              - $signed({i_s_axis_tdata[63], i_s_axis_tdata[63:32]});

    always_comb begin
        n_s1_ax = dx[32] ? 32'(-dx) : dx[31:0];
        n_s1_ay = dy[32] ? 32'(-dy) : dy[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ax <= n_s1_ax;
            r_s1_ay <= n_s1_ay;
            r_s1_nx <= dx[32];
            r_s1_ny <= dy[32];
            r_s1_hs <= $signed(i_s_axis_tdata[82:64]);
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: squares and the bit length of the larger magnitude.
    logic [31:0]        m_or;
    logic [5:0]         n_s2_len;
    logic               r_s2_v;
    logic [63:0]        r_s2_px;
    logic [63:0]        r_s2_py;
    logic [5:0]         r_s2_len;
    logic [31:0]        r_s2_ax;
    logic [31:0]        r_s2_ay;
    logic               r_s2_nx;
    logic               r_s2_ny;
    logic signed [18:0] r_s2_hs;

    assign m_or = r_s1_ax | r_s1_ay;

    always_comb begin
        n_s2_len = 6'd0;
        for (int i = 0; i < 32; i++) begin
            if (m_or[i]) begin
                n_s2_len = 6'(i + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_px  <= r_s1_ax * r_s1_ax;
            r_s2_py  <= r_s1_ay * r_s1_ay;
            r_s2_len <= n_s2_len;
            r_s2_ax  <= r_s1_ax;
            r_s2_ay  <= r_s1_ay;
            r_s2_nx  <= r_s1_nx;
            r_s2_ny  <= r_s1_ny;
            r_s2_hs  <= r_s1_hs;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: squared distance and CORDIC normalization to bit 40.
    logic               r_s3_v;
    logic [64:0]        r_s3_d2;
    logic [63:0]        r_s3_px;
    logic [63:0]        r_s3_py;
    logic [31:0]        r_s3_ax;
    logic [31:0]        r_s3_ay;
    logic               r_s3_nx;
    logic               r_s3_ny;
    logic               r_s3_axz;
    logic               r_s3_ayz;
    logic signed [18:0] r_s3_hs;
    logic signed [43:0] r_s3_cx;
    logic signed [43:0] r_s3_cy;
    logic [5:0]         nshift;

    assign nshift = 6'd41 - r_s2_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_d2  <= {1'b0, r_s2_px} + {1'b0, r_s2_py};
            r_s3_px  <= r_s2_px;
            r_s3_py  <= r_s2_py;
            r_s3_ax  <= r_s2_ax;
            r_s3_ay  <= r_s2_ay;
            r_s3_nx  <= r_s2_nx;
            r_s3_ny  <= r_s2_ny;
            r_s3_axz <= (r_s2_ax == 32'd0);
            r_s3_ayz <= (r_s2_ay == 32'd0);
            r_s3_hs  <= r_s2_hs;
            r_s3_cx  <= $signed({12'd0, r_s2_ax} << nshift);
            r_s3_cy  <= $signed({12'd0, r_s2_ay} << nshift);
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: start values of the dividers, roots and CORDIC.
    t_work       n_s4_w;
    t_work       r_s4_w;
    logic        r_s4_v;
    logic        rx_top;
    logic        ry_top;

    always_comb begin
        rx_top = ({1'b0, r_s3_px} >= r_s3_d2);
        ry_top = ({1'b0, r_s3_py} >= r_s3_d2);
        n_s4_w         = '0;
        n_s4_w.hs      = r_s3_hs;
        n_s4_w.nx      = r_s3_nx;
        n_s4_w.ny      = r_s3_ny;
        n_s4_w.zero    = r_s3_axz && r_s3_ayz;
        n_s4_w.axz     = r_s3_axz;
        n_s4_w.ayz     = r_s3_ayz;
        n_s4_w.d2      = r_s3_d2;
        n_s4_w.rg_rem  = r_s3_d2;
        n_s4_w.qx_rem  = {33'd0, r_s3_ax};
        n_s4_w.qx_ov   = ({33'd0, r_s3_ax} >= r_s3_d2);
        n_s4_w.qy_rem  = {33'd0, r_s3_ay};
        n_s4_w.qy_ov   = ({33'd0, r_s3_ay} >= r_s3_d2);
        n_s4_w.rx_rem  = rx_top ? ({1'b0, r_s3_px} - r_s3_d2) : {1'b0, r_s3_px};
        n_s4_w.rx_q    = {32'd0, rx_top};
        n_s4_w.ry_rem  = ry_top ? ({1'b0, r_s3_py} - r_s3_d2) : {1'b0, r_s3_py};
        n_s4_w.ry_q    = {32'd0, ry_top};
        n_s4_w.cx      = r_s3_cx;
        n_s4_w.cy      = r_s3_cy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else if (en) begin
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_w <= n_s4_w;
        end
    end

    // ---------------------------------------------------------------
    // Iteration stages.
    logic  it_v;
    t_work it_w;

    rbj_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s4_v),
        .i_work  (r_s4_w),
        .o_valid (it_v),
        .o_work  (it_w)
    );

    // ---------------------------------------------------------------
    // Finish 1: quadrant angle, range saturation, signed Jacobian terms.
    logic signed [34:0] n_f1_a;
    logic signed [34:0] zc;
    logic [199:0]       n_f1_jac;
    logic [RANGE_BITS-1:0] n_f1_range;
    logic               r_f1_v;
    logic signed [34:0] r_f1_a;
    logic signed [18:0] r_f1_hs;
    logic [RANGE_BITS-1:0] r_f1_range;
    logic [199:0]       r_f1_jac;
    logic               r_f1_zero;

    always_comb begin
        zc = 35'(it_w.cz);
        if (zc < 35'sd0) begin
            zc = 35'sd0;
        end else if (zc > HALF_PI_Q30) begin
            zc = HALF_PI_Q30;
        end
        if (it_w.zero || it_w.ayz) begin
            n_f1_a = 35'sd0;
        end else if (it_w.axz) begin
            n_f1_a = HALF_PI_Q30;
        end else begin
            n_f1_a = zc;
        end
        if (!it_w.zero && it_w.nx) begin
            n_f1_a = PI_Q30 - n_f1_a;
        end
        if (!it_w.zero && it_w.ny) begin
            n_f1_a = -n_f1_a;
        end
        n_f1_range = (it_w.rg_root[32:31] != 2'd0) ? {RANGE_BITS{1'b1}} : it_w.rg_root[30:0];
        if (it_w.zero) begin
            n_f1_jac = '0;
        end else begin
            n_f1_jac = {sat_db(it_w.qx_q, it_w.qx_ov, !it_w.nx),
                        enc_dr(it_w.ry_root, !it_w.ny),
                        sat_db(it_w.qy_q, it_w.qy_ov, it_w.ny),
                        enc_dr(it_w.rx_root, !it_w.nx),
                        sat_db(it_w.qx_q, it_w.qx_ov, it_w.nx),
                        enc_dr(it_w.ry_root, it_w.ny),
                        sat_db(it_w.qy_q, it_w.qy_ov, !it_w.ny),
                        enc_dr(it_w.rx_root, it_w.nx)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
        end else if (en) begin
            r_f1_v <= it_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_a     <= n_f1_a;
            r_f1_hs    <= it_w.hs;
            r_f1_range <= n_f1_range;
            r_f1_jac   <= n_f1_jac;
            r_f1_zero  <= it_w.zero;
        end
    end

    // ---------------------------------------------------------------
    // Finish 2: subtract the heading scaled to Q30.
    logic signed [34:0] hs_ext;
    logic               r_f2_v;
    logic signed [34:0] r_f2_b;
    logic [RANGE_BITS-1:0] r_f2_range;
    logic [199:0]       r_f2_jac;
    logic               r_f2_zero;

    assign hs_ext = r_f1_hs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_v <= 1'b0;
        end else if (en) begin
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f2_b     <= r_f1_a - (hs_ext <<< (30 - FRAC_BITS));
            r_f2_range <= r_f1_range;
            r_f2_jac   <= r_f1_jac;
            r_f2_zero  <= r_f1_zero;
        end
    end

    // ---------------------------------------------------------------
    // Finish 3: wrap into [-pi, pi]; exactly pi stays positive.
    logic signed [34:0] n_f3_b;
    logic               r_f3_v;
    logic signed [34:0] r_f3_b;
    logic [RANGE_BITS-1:0] r_f3_range;
    logic [199:0]       r_f3_jac;
    logic               r_f3_zero;

    always_comb begin
        if (r_f2_b > PI_Q30) begin
            n_f3_b = r_f2_b - TWO_PI_Q30;
        end else if (r_f2_b < -PI_Q30) begin
            n_f3_b = r_f2_b + TWO_PI_Q30;
        end else begin
            n_f3_b = r_f2_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f3_v <= 1'b0;
        end else if (en) begin
            r_f3_v <= r_f2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f3_b     <= n_f3_b;
            r_f3_range <= r_f2_range;
            r_f3_jac   <= r_f2_jac;
            r_f3_zero  <= r_f2_zero;
        end
    end

    // ---------------------------------------------------------------
    // Finish 4 and output register: round the bearing half away from zero.
    logic [31:0]          bmag;
    logic [32:0]          bsum;
    logic [HEAD_BITS-1:0] bq;
    logic [HEAD_BITS-1:0] n_o_bearing;
    logic [HEAD_BITS-1:0] r_o_bearing;
    logic [RANGE_BITS-1:0] r_o_range;
    logic [199:0]         r_o_jac;
    logic                 r_o_zero;

    always_comb begin
        bmag = (r_f3_b < 35'sd0) ? 32'(-r_f3_b) : 32'(r_f3_b);
        bsum = {1'b0, bmag} + (33'd1 << (30 - FRAC_BITS - 1));
        bq   = HEAD_BITS'(bsum >> (30 - FRAC_BITS));
        n_o_bearing = (r_f3_b < 35'sd0) ? (HEAD_BITS'(0) - bq) : bq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (en) begin
            r_o_v <= r_f3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_bearing <= n_o_bearing;
            r_o_range   <= r_f3_range;
            r_o_jac     <= r_f3_jac;
            r_o_zero    <= r_f3_zero;
        end
    end

    assign o_m_axis_tvalid = r_o_v;
    assign o_m_axis_tdata  = {6'd0, r_o_jac, r_o_bearing, r_o_range};
    assign o_m_axis_tuser  = r_o_zero;

endmodule

### rtl/rbj_checker.sv
module rbj_checker import rbj_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_m_axis_tvalid,
    input logic                i_m_axis_tready,
    input logic [OUT_BITS-1:0] o_m_axis_tdata,
    input logic                o_m_axis_tuser
);

    logic signed [HEAD_BITS-1:0] bearing;

    assign bearing = $signed(o_m_axis_tdata[49:31]);

    // A reset cycle leaves the output empty.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output word valid right after reset");

    // A stalled result word stays in place.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata)
        && $stable(o_m_axis_tuser))
        else $error("stalled output word changed");

    // Zero range goes together with the coincident-landmark flag.
    a_zero_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser == (o_m_axis_tdata[30:0] == 31'd0)))
        else $error("range and zero distance flag disagree");

    // A coincident landmark gives all-zero Jacobians.
    a_zero_jac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> (o_m_axis_tdata[249:50] == 200'd0))
        else $error("Jacobian not zero for coincident landmark");

    // Bearing stays within minus pi to pi.
    a_bearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (bearing <= 19'sd205887) && (bearing >= -19'sd205887))
        else $error("bearing outside minus pi to pi");

endmodule

bind range_bearing_measurement_jacobian_unit rbj_checker u_rbj_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench import rbj_pkg::*;;

    // One pose and landmark pair as driven on the input channel.
    typedef struct {
        logic [31:0] veh_x;
        logic [31:0] veh_y;
        logic [18:0] heading;
        logic [31:0] lm_x;
        logic [31:0] lm_y;
        bit          hold;
    } t_pose_pair;

    // Predicted observation word plus the zero-distance flag.
    typedef struct {
        logic [OUT_BITS-1:0] data;
        logic                zero;
    } t_observation;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [IN_BITS-1:0]  i_s_axis_tdata = '0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0] o_m_axis_tdata;
    logic                o_m_axis_tuser;

    range_bearing_measurement_jacobian_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    localparam int IDLE_LIMIT = 3000;
    localparam longint PI_Q = 64'sd3373259426;
    localparam longint TWO_PI_Q = 64'sd6746518852;
    localparam longint HALF_PI_Q = 64'sd1686629713;

    // Output field layout, lowest bit up.
    string field_name[10] = '{"range", "bearing", "drange_dlm_x", "dbearing_dlm_x",
        "drange_dlm_y", "dbearing_dlm_y", "drange_dveh_x", "dbearing_dveh_x",
        "drange_dveh_y", "dbearing_dveh_y"};
    int field_width[10] = '{31, 19, 18, 32, 18, 32, 18, 32, 18, 32};

    t_pose_pair   pose_queue[$];
    t_observation pending_observations[$];
    int           error_count = 0;
    int           idle_cycles = 0;
    bit           in_taken = 1'b0;
    bit           stimulus_done = 1'b0;
    int           burst_left = 0;
    int           gap_left = 0;
    int           stall_mode = 0;
    int           stall_left = 0;

    // Integer square root of a 128-bit value.
    function automatic logic [63:0] isqrt128(logic [127:0] n);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= n) r = c;
        end
        return r;
    endfunction

    // First-quadrant angle in Q30 by CORDIC vectoring.
    function automatic longint angle_q1(logic [63:0] ax, logic [63:0] ay);
        longint tab[10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
            33543515, 16775850, 8388437, 4194282, 2097149};
        logic [63:0] m;
        int          len;
        longint      x, y, z, t, xs, ys;
        if (ay == 0) return 0;
        if (ax == 0) return HALF_PI_Q;
        m = (ax > ay) ? ax : ay;
        len = 0;
        while (len < 64 && (m >> len) != 0) len++;
        if (len > 41) begin
            ax = ax >> (len - 41);
            ay = ay >> (len - 41);
        end else begin
            ax = ax << (41 - len);
            ay = ay << (41 - len);
        end
        x = ax;
        y = ay;
        z = 0;
        for (int i = 0; i <= 30 && y != 0; i++) begin
            t = (i < 10) ? tab[i] : (64'sd1 <<< (30 - i));
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys; y -= xs; z += t;
            end else begin
                x -= ys; y += xs; z -= t;
            end
        end
        if (z < 0) z = 0;
        if (z > HALF_PI_Q) z = HALF_PI_Q;
        return z;
    endfunction

    // Saturate a quotient magnitude to the signed word range and apply the sign.
    function automatic logic [31:0] sat_word(logic [127:0] q, bit neg);
        logic [127:0] lim;
        logic [31:0]  m;
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        m = (q > lim) ? lim[31:0] : q[31:0];
        return neg ? -m : m;
    endfunction

    function automatic t_observation predict_observation(t_pose_pair p);
        t_observation o;
        logic signed [32:0] dx, dy;
        logic [63:0]  ax, ay;
        logic [127:0] d2, qx, qy;
        logic [63:0]  r, rx, ry;
        bit           nx, ny, zero;
        longint       a, b, hs, bmag;
        logic [18:0]  bear;
        logic [17:0]  rxp, ryp;
        dx = $signed({p.lm_x[31], p.lm_x}) - $signed({p.veh_x[31], p.veh_x});
        dy = $signed({p.lm_y[31], p.lm_y}) - $signed({p.veh_y[31], p.veh_y});
        nx = dx < 0;
        ny = dy < 0;
        ax = nx ? 64'(-dx) : 64'(dx);
        ay = ny ? 64'(-dy) : 64'(dy);
        d2 = {64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay};
        r = isqrt128(d2);
        zero = (ax == 0 && ay == 0);
        hs = $signed(p.heading);
        a = zero ? 0 : angle_q1(ax, ay);
        if (!zero && nx) a = PI_Q - a;
        if (!zero && ny) a = -a;
        b = a - hs * 16384;
        while (b > PI_Q) b -= TWO_PI_Q;
        while (b < -PI_Q) b += TWO_PI_Q;
        bmag = (b < 0) ? -b : b;
        bmag = (bmag + 8192) >>> 14;
        bear = (b < 0) ? -19'(bmag) : 19'(bmag);
        o.data = '0;
        o.zero = zero;
        o.data[30:0] = (r > 64'h7fff_ffff) ? 31'h7fff_ffff : r[30:0];
        o.data[49:31] = bear;
        if (!zero) begin
            rx = isqrt128((({64'd0, ax} * {64'd0, ax}) << 32) / d2);
            ry = isqrt128((({64'd0, ay} * {64'd0, ay}) << 32) / d2);
            qy = ({64'd0, ay} << 32) / d2;
            qx = ({64'd0, ax} << 32) / d2;
            rxp = rx[17:0];
            ryp = ry[17:0];
            o.data[67:50]   = nx ? -rxp : rxp;
            o.data[99:68]   = sat_word(qy, !ny);
            o.data[117:100] = ny ? -ryp : ryp;
            o.data[149:118] = sat_word(qx, nx);
            o.data[167:150] = nx ? rxp : -rxp;
            o.data[199:168] = sat_word(qy, ny);
            o.data[217:200] = ny ? ryp : -ryp;
            o.data[249:218] = sat_word(qx, !nx);
        end
        return o;
    endfunction

    function automatic void add_pose(logic [31:0] vx, logic [31:0] vy, logic [18:0] h,
                                     logic [31:0] lx, logic [31:0] ly, bit hold);
        t_pose_pair p;
        p.veh_x = vx; p.veh_y = vy; p.heading = h;
        p.lm_x = lx; p.lm_y = ly; p.hold = hold;
        pose_queue.push_back(p);
    endfunction

    function automatic logic [18:0] rand_heading();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 19'($urandom);
        return 19'($urandom_range(0, 411774) - 205887);
    endfunction

    // Stimulus: directed corners, then random pose pairs.
    initial begin
        logic [31:0] vx, vy, lx, ly;
        int sel;
        // Landmark on the vehicle, at several headings.
        add_pose(32'd0, 32'd0, 19'd0, 32'd0, 32'd0, 1'b0);
        add_pose(32'h8000_0000, 32'h7fff_ffff, 19'd205887, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
        add_pose(32'h1234_5678, 32'hfedc_ba98, -19'd205887, 32'h1234_5678, 32'hfedc_ba98,
                 1'b0);
        add_pose(32'd5, 32'd5, 19'h3ffff, 32'd5, 32'd5, 1'b0);
        add_pose(32'hffff_ffff, 32'd0, 19'h40000, 32'hffff_ffff, 32'd0, 1'b0);
        // Far landmark: range saturates.
        add_pose(32'h8000_0000, 32'h8000_0000, 19'd0, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        add_pose(32'h7fff_ffff, 32'h7fff_ffff, 19'd1000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        add_pose(32'h7fff_ffff, 32'h8000_0000, 19'd0, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
        // Axis directions.
        add_pose(32'd0, 32'd0, 19'd0, 32'd0, 32'h0001_0000, 1'b0);
        add_pose(32'd0, 32'd0, 19'd0, 32'd0, 32'hffff_0000, 1'b0);
        add_pose(32'd0, 32'd0, 19'd0, 32'h0003_0000, 32'd0, 1'b0);
        // Bearing exactly pi stays positive.
        add_pose(32'd0, 32'd0, 19'd0, 32'hfffd_0000, 32'd0, 1'b0);
        add_pose(32'd0, 32'd0, -19'd205887, 32'd10, 32'd0, 1'b0);
        // Near landmark: rate terms grow large and can saturate.
        add_pose(32'd100, 32'd100, 19'd0, 32'd101, 32'd100, 1'b0);
        add_pose(32'd100, 32'd100, 19'd0, 32'd100, 32'd99, 1'b0);
        add_pose(32'd0, 32'd0, 19'd0, 32'hffff_ffff, 32'd1, 1'b0);
        add_pose(32'd0, 32'd0, 19'd0, 32'h0000_0100, 32'hffff_ff00, 1'b0);
        // Headings outside the nominal span.
        add_pose(32'd0, 32'd0, 19'h3ffff, 32'h0001_0000, 32'h0002_0000, 1'b0);
        add_pose(32'd0, 32'd0, 19'h40000, 32'hffff_0000, 32'h0002_0000, 1'b1);
        for (int n = 0; n < 450; n++) begin
            sel = $urandom_range(0, 9);
            vx = $urandom; vy = $urandom;
            if (sel < 3) begin
                lx = $urandom; ly = $urandom;
            end else if (sel < 6) begin
                lx = vx + 32'($urandom_range(0, 2 << 20) - (1 << 20));
                ly = vy + 32'($urandom_range(0, 2 << 20) - (1 << 20));
            end else if (sel < 8) begin
                lx = vx + 32'($urandom_range(0, 8) - 4);
                ly = vy + 32'($urandom_range(0, 8) - 4);
            end else if (sel < 9) begin
                lx = ($urandom_range(0, 1)) ? vx : vx + $urandom;
                ly = (lx == vx) ? vy + $urandom : vy;
            end else begin
                lx = vx; ly = vy;
            end
            add_pose(vx, vy, rand_heading(), lx, ly, (n % 150) == 149);
        end
        stimulus_done = 1'b1;
    end

    // Reset, then wait for the pipeline to drain before the verdict.
    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (stimulus_done && pose_queue.size() == 0 && !i_s_axis_tvalid &&
              pending_observations.size() == 0);
        repeat (100) @(posedge i_clk);
        if (error_count == 0 && pending_observations.size() == 0) begin
            $display("range_bearing_measurement_jacobian_unit: match");
        end else begin
            $display("range_bearing_measurement_jacobian_unit: mismatch");
        end
        $finish;
    end

    // Driver: bursts and gaps, with a drain pause on marked words.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || in_taken) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (pose_queue.size() != 0 &&
                         !(pose_queue[0].hold && pending_observations.size() != 0)) begin
                i_s_axis_tdata <= {5'd0, pose_queue[0].lm_y, pose_queue[0].lm_x,
                                   pose_queue[0].heading, pose_queue[0].veh_y,
                                   pose_queue[0].veh_x};
                void'(pose_queue.pop_front());
                i_s_axis_tvalid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern: free-running, random, or mostly stalled.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 120);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: begin
                i_m_axis_tready <= 1'b1;
            end
            1: begin
                i_m_axis_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
                i_m_axis_tready <= ($urandom_range(0, 7) == 0);
            end
        endcase
    end

    // Monitor: predict on input words, check output words, watch for a hang.
    always @(posedge i_clk) begin
        t_observation want;
        logic [31:0]  got_f, want_f;
        int           lsb;
        in_taken <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            pending_observations.push_back(predict_observation('{
                i_s_axis_tdata[31:0], i_s_axis_tdata[63:32], i_s_axis_tdata[82:64],
                i_s_axis_tdata[114:83], i_s_axis_tdata[146:115], 1'b0}));
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_observations.size() == 0) begin
                $error("unexpected output word");
                error_count++;
            end else begin
                want = pending_observations.pop_front();
                lsb = 0;
                for (int f = 0; f < 10; f++) begin
                    got_f = 32'((o_m_axis_tdata >> lsb)
                                & ((256'd1 << field_width[f]) - 256'd1));
                    want_f = 32'((want.data >> lsb)
                                 & ((256'd1 << field_width[f]) - 256'd1));
                    if (got_f !== want_f) begin
                        $error("%s: expected %h, got %h", field_name[f], want_f, got_f);
                        error_count++;
                    end
                    lsb += field_width[f];
                end
                if (o_m_axis_tuser !== want.zero) begin
                    $error("zero_distance: expected %b, got %b", want.zero, o_m_axis_tuser);
                    error_count++;
                end
            end
        end
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("range_bearing_measurement_jacobian_unit: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

### sim.f
rtl/rbj_pkg.sv
rtl/rbj_iter.sv
rtl/range_bearing_measurement_jacobian_unit.sv
rtl/rbj_checker.sv
dv/testbench.sv
